// ----- rtl/core/mwfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mwfd_pkg;

  localparam int ADDR_BITS = 6;
  localparam int DATA_BITS = 16;
  localparam int HEAD_BITS = 2 + ADDR_BITS;
  localparam int FULL_BITS = 2 + ADDR_BITS + DATA_BITS;
  localparam int CNT_W     = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Beat kinds on tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_EOF    = 1'b1;

  // Primary opcode (two bits after the start bit)
  localparam logic [1:0] OP_EXT   = 2'b00;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_ERASE = 2'b11;

  // Extended opcode (next two bits when the primary opcode is OP_EXT)
  localparam logic [1:0] EXT_EWDS = 2'b00;
  localparam logic [1:0] EXT_WRAL = 2'b01;
  localparam logic [1:0] EXT_ERAL = 2'b10;
  localparam logic [1:0] EXT_EWEN = 2'b11;

  typedef enum logic [2:0] {
    INSTR_READ     = 3'd0,
    INSTR_ERASE    = 3'd1,
    INSTR_WRITE    = 3'd2,
    INSTR_EWEN     = 3'd3,
    INSTR_EWDS     = 3'd4,
    INSTR_ERAL     = 3'd5,
    INSTR_WRAL     = 3'd6,
    INSTR_NO_START = 3'd7
  } instr_t;

  // One lane's control status
  typedef struct packed {
    logic             started;
    logic [CNT_W-1:0] count;
  } lane_stat_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_word;
    logic                 read_complete;
    logic [DATA_BITS-1:0] write_word;
    logic [ADDR_BITS-1:0] word_address;
    logic                 command_complete;
    instr_t               instruction;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/microwire_eeprom_frame_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Microwire (93C46, x16) frame decoder. Each input beat is one bus clock
// period sample of MOSI and MISO with per-pin bad-quality flags
// (tuser = 0), or an end-of-frame mark when chip select drops (tuser = 1).
// On MOSI the first good 1 is the start bit, followed by the opcode (2 bits,
// or 4 for the extended forms), a 6-bit word address and 16 write-data
// bits, MSB first. On MISO the first good 0 is the dummy bit and the next 16
// bits are the read word. Each end-of-frame beat yields exactly one result
// beat, and the frame state clears for the next frame; sample beats yield
// nothing. Bits beyond the expected length are ignored. One input beat is
// accepted per clock while s_tready is high; the end-of-frame result is
// registered in the output register, or in the skid buffer if it is stalled.
// The result register plus a one-entry skid buffer keep s_tready high while
// a single result waits downstream; s_tready drops only when both are full.
module microwire_eeprom_frame_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] mosi_bit, [1] mosi_bad, [2] miso_bit,
                                      // [3] miso_bad, [7:4] zero
  input  wire logic        s_tuser,   // [0] cmd: 0 sample, 1 end of frame
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // [2:0] instruction, [3] command_complete,
                                      // [9:4] word_address, [25:10] write_word,
                                      // [26] read_complete, [42:27] read_word,
                                      // [47:43] zero
);

  logic                 s_beat;
  logic                 sample;
  logic                 eof;
  logic                 out_take;

  mwfd_pkg::lane_stat_t                 mosi_stat;
  mwfd_pkg::lane_stat_t                 miso_stat;
  logic [mwfd_pkg::FULL_BITS-1:0]       mosi_shift;
  logic [mwfd_pkg::DATA_BITS-1:0]       miso_shift;
  mwfd_pkg::result_t                    res_new;

  // Result register and skid stage
  mwfd_pkg::result_t    out_res;
  logic                 out_valid;
  mwfd_pkg::result_t    skid_res;
  logic                 skid_valid;

  assign s_tready = !skid_valid;
  assign s_beat   = s_tvalid && s_tready;
  assign sample   = s_beat && (s_tuser == mwfd_pkg::CMD_SAMPLE);
  assign eof      = s_beat && (s_tuser == mwfd_pkg::CMD_EOF);
  assign out_take = out_valid && m_tready;

  mwfd_lane #(
    .WIDTH     (mwfd_pkg::FULL_BITS),
    .START_LVL (1'b1)
  ) u_mosi (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .clear  (eof),
    .bit_in (s_tdata[0]),
    .bad_in (s_tdata[1]),
    .stat   (mosi_stat),
    .shift  (mosi_shift)
  );

  mwfd_lane #(
    .WIDTH     (mwfd_pkg::DATA_BITS),
    .START_LVL (1'b0)
  ) u_miso (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .clear  (eof),
    .bit_in (s_tdata[2]),
    .bad_in (s_tdata[3]),
    .stat   (miso_stat),
    .shift  (miso_shift)
  );

  mwfd_decode u_decode (
    .mosi_stat  (mosi_stat),
    .mosi_shift (mosi_shift),
    .miso_stat  (miso_stat),
    .miso_shift (miso_shift),
    .res        (res_new)
  );

  // Control: skid drains into the output register first; a new result goes
  // straight to the output register when it is free or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (eof) begin
      if (out_valid && !m_tready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_res <= skid_res;
      end
    end else if (eof) begin
      if (out_valid && !m_tready) begin
        skid_res <= res_new;
      end else begin
        out_res <= res_new;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0,
                     out_res.read_word,
                     out_res.read_complete,
                     out_res.write_word,
                     out_res.word_address,
                     out_res.command_complete,
                     out_res.instruction};

  // Skid never holds a beat unless the output register is full.
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  // End of frame arriving against a stalled full output lands in the skid.
  a_eof_to_skid: assert property (@(posedge clk) disable iff (rst)
    (eof && out_valid && !m_tready) |=> skid_valid)
    else $error("end-of-frame result lost on stalled output");

  // Skid drains when downstream takes the output.
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> (out_valid && !skid_valid))
    else $error("skid did not drain into output register");

  // Frame state is cleared after every end of frame.
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    eof |=> (!mosi_stat.started && !miso_stat.started &&
             mosi_stat.count == '0 && miso_stat.count == '0))
    else $error("frame state not cleared after end of frame");

  // Counters only advance once their lane has seen its marker bit.
  a_count_needs_start: assert property (@(posedge clk) disable iff (rst)
    (mosi_stat.count != '0) |-> mosi_stat.started)
    else $error("MOSI bit count advanced without start bit");

endmodule

`default_nettype wire

// ----- rtl/core/mwfd_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One serial lane: hunt for the marker bit, then place bit k at WIDTH-1-k.
module mwfd_lane #(
  parameter int   WIDTH     = mwfd_pkg::DATA_BITS,
  parameter logic START_LVL = 1'b1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample,
  input  wire logic                clear,
  input  wire logic                bit_in,
  input  wire logic                bad_in,
  output mwfd_pkg::lane_stat_t     stat,
  output logic [WIDTH-1:0]         shift
);

  mwfd_pkg::lane_stat_t stat_next;
  logic [WIDTH-1:0]     shift_next;

  always_comb begin
    stat_next  = stat;
    shift_next = shift;
    if (clear) begin
      stat_next  = '0;
      shift_next = '0;
    end else if (sample) begin
      if (!stat.started) begin
        if (bit_in == START_LVL && !bad_in) begin
          stat_next.started = 1'b1;
        end
      end else begin
        for (int i = 0; i < WIDTH; i++) begin
          if (stat.count == mwfd_pkg::CNT_W'(WIDTH - 1 - i)) begin
            shift_next[i] = shift[i] | bit_in;
          end
        end
        if (stat.count != mwfd_pkg::CNT_MAX) begin
          stat_next.count = stat.count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      shift <= '0;
    end else begin
      stat  <= stat_next;
      shift <= shift_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mwfd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Frame decode from the lane registers, evaluated on the end-of-frame beat.
module mwfd_decode (
  input  wire mwfd_pkg::lane_stat_t              mosi_stat,
  input  wire logic [mwfd_pkg::FULL_BITS-1:0]    mosi_shift,
  input  wire mwfd_pkg::lane_stat_t              miso_stat,
  input  wire logic [mwfd_pkg::DATA_BITS-1:0]    miso_shift,
  output mwfd_pkg::result_t                      res
);

  logic [1:0]                op;
  logic [1:0]                ext;
  logic                      uses_addr;
  logic                      uses_data;
  logic                      full_need;
  logic                      complete;
  mwfd_pkg::instr_t          instr;

  assign op  = mosi_shift[mwfd_pkg::FULL_BITS-1 -: 2];
  assign ext = mosi_shift[mwfd_pkg::FULL_BITS-3 -: 2];

  always_comb begin
    instr     = mwfd_pkg::INSTR_WRAL;
    uses_addr = 1'b0;
    uses_data = 1'b0;
    full_need = 1'b0;
    case (op)
      mwfd_pkg::OP_READ: begin
        instr     = mwfd_pkg::INSTR_READ;
        uses_addr = 1'b1;
      end
      mwfd_pkg::OP_ERASE: begin
        instr     = mwfd_pkg::INSTR_ERASE;
        uses_addr = 1'b1;
      end
      mwfd_pkg::OP_WRITE: begin
        instr     = mwfd_pkg::INSTR_WRITE;
        uses_addr = 1'b1;
        uses_data = 1'b1;
        full_need = 1'b1;
      end
      default: begin
        case (ext)
          mwfd_pkg::EXT_EWEN: instr = mwfd_pkg::INSTR_EWEN;
          mwfd_pkg::EXT_EWDS: instr = mwfd_pkg::INSTR_EWDS;
          mwfd_pkg::EXT_ERAL: instr = mwfd_pkg::INSTR_ERAL;
          default: begin
            instr     = mwfd_pkg::INSTR_WRAL;
            uses_data = 1'b1;
            full_need = 1'b1;
          end
        endcase
      end
    endcase
  end

  assign complete = full_need ?
      (mosi_stat.count >= mwfd_pkg::CNT_W'(mwfd_pkg::FULL_BITS)) :
      (mosi_stat.count >= mwfd_pkg::CNT_W'(mwfd_pkg::HEAD_BITS));

  always_comb begin
    res = '0;
    res.instruction = mwfd_pkg::INSTR_NO_START;
    if (mosi_stat.started) begin
      res.instruction      = instr;
      res.command_complete = complete;
      if (complete && uses_addr) begin
        res.word_address = mosi_shift[mwfd_pkg::DATA_BITS +: mwfd_pkg::ADDR_BITS];
      end
      if (complete && uses_data) begin
        res.write_word = mosi_shift[mwfd_pkg::DATA_BITS-1:0];
      end
    end
    if (miso_stat.started &&
        miso_stat.count >= mwfd_pkg::CNT_W'(mwfd_pkg::DATA_BITS)) begin
      res.read_complete = 1'b1;
      res.read_word     = miso_shift;
    end
  end

endmodule

`default_nettype wire
